// ===== src/setcap_pkg.sv =====
// Shared types and constants of the scope edge trigger capture block.
// No dependencies; every other file of the block but setcap_ram imports this package.
package setcap_pkg;

  localparam int unsigned DepthDefault = 1024;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned OffW         = 10;
  localparam int unsigned PrescaleW    = 24;
  localparam int unsigned CfgDataW     = 24;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned AutoBuffers  = 8;
  localparam int unsigned RedSteps     = 8;

  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdRead  = 2'd1,
    CmdRearm = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    EdgeRising  = 2'd0,
    EdgeFalling = 2'd1,
    EdgeBoth    = 2'd2
  } edge_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPrescale  = 2'd0,
    CfgThreshold = 2'd1,
    CfgEdgeMode  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CapRunning   = 2'd0,
    CapTriggered = 2'd1,
    CapAvailable = 2'd2
  } cap_state_e;

  typedef enum logic [2:0] {
    ModeRun   = 3'b001,
    ModeTrig  = 3'b010,
    ModeAvail = 3'b100
  } mode_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [SampleW-1:0] sample;
    logic [OffW-1:0]           read_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                capture_state;
    logic signed [SampleW-1:0] read_data;
    logic                      trigger_event;
    logic                      auto_event;
    logic                      sample_stored;
  } out_item_t;

  typedef struct packed {
    logic                 en;
    logic [CfgIdxW-1:0]   idx;
    logic [CfgDataW-1:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    cap_state_e capture_state;
    logic       trigger_event;
    logic       auto_event;
    logic       sample_stored;
    logic       read_hit;
  } res_meta_t;

endpackage

// ===== src/setcap_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module setcap_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/setcap_ctrl.sv =====
// Capture control: config registers, prescaler, trigger detection and the
// write index/mode state update per transfer. Depends on setcap_pkg.
module setcap_ctrl #(
  parameter int unsigned DEPTH = setcap_pkg::DepthDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  setcap_pkg::cfg_wr_t        cfg_i,
  input  logic                       acc_i,
  input  setcap_pkg::in_item_t       item_i,
  output logic                       mem_we_o,
  output logic [$clog2(DEPTH)-1:0]   mem_waddr_o,
  output logic [setcap_pkg::SampleW-1:0] mem_wdata_o,
  output logic                       mem_re_o,
  output logic [$clog2(DEPTH)-1:0]   mem_raddr_o,
  output setcap_pkg::res_meta_t      meta_o
);
  import setcap_pkg::*;

  localparam int unsigned IdxW    = $clog2(DEPTH);
  localparam int unsigned PreW    = $clog2(AutoBuffers * DEPTH + 1);
  localparam int unsigned PostW   = $clog2(DEPTH / 2);
  localparam int unsigned SumW    = ((IdxW > OffW) ? IdxW : OffW) + 1;
  localparam int unsigned Half    = DEPTH / 2;
  localparam int unsigned PostMax = DEPTH / 2 - 1;
  localparam int unsigned AutoMax = AutoBuffers * DEPTH;

  logic [PrescaleW-1:0]      prescale_q;
  logic signed [SampleW-1:0] thr_q;
  logic [1:0]                edge_q;

  logic [PrescaleW-1:0]      tick_q, tick_d;
  logic [IdxW-1:0]           wi_q, wi_d;
  logic                      wrapped_q, wrapped_d;
  logic [PreW-1:0]           pre_q, pre_d;
  logic [PostW-1:0]          post_q, post_d;
  mode_e                     mode_q, mode_d;
  logic signed [SampleW-1:0] last_q, last_d;

  logic [PrescaleW:0]        tick_inc;
  logic                      fire;
  logic [PreW-1:0]           pre_inc;
  logic                      up, down, crossed;
  logic [IdxW-1:0]           wi_next;
  logic [OffW-1:0]           off_r;
  logic [SumW-1:0]           rsum;
  logic                      trig, autot, stored, rd_item;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      thr_q      <= '0;
      edge_q     <= '0;
    end else if (cfg_i.en) begin
      unique case (cfg_i.idx)
        CfgPrescale:  prescale_q <= cfg_i.data[PrescaleW-1:0];
        CfgThreshold: thr_q      <= cfg_i.data[SampleW-1:0];
        CfgEdgeMode:  edge_q     <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  assign tick_inc = {1'b0, tick_q} + {{PrescaleW{1'b0}}, 1'b1};
  assign fire     = tick_inc > {1'b0, prescale_q};
  assign pre_inc  = pre_q + PreW'(1);
  assign wi_next  = (wi_q == IdxW'(DEPTH - 1)) ? '0 : wi_q + IdxW'(1);

  assign up   = (item_i.sample > thr_q) && (last_q < thr_q);
  assign down = (item_i.sample < thr_q) && (last_q > thr_q);

  always_comb begin
    unique case (edge_q)
      EdgeRising:  crossed = up;
      EdgeFalling: crossed = down;
      EdgeBoth:    crossed = up || down;
      default:     crossed = 1'b0;
    endcase
  end

  // reduce the offset modulo DEPTH, then wrap the sum once
  always_comb begin
    off_r = item_i.read_offset;
    for (int k = RedSteps - 1; k >= 0; k--) begin
      if (32'(off_r) >= (32'(DEPTH) << k)) begin
        off_r = off_r - OffW'(32'(DEPTH) << k);
      end
    end
    rsum = SumW'(wi_q) + SumW'(off_r);
    if (rsum >= SumW'(DEPTH)) begin
      rsum = rsum - SumW'(DEPTH);
    end
  end

  always_comb begin
    tick_d    = tick_q;
    wi_d      = wi_q;
    wrapped_d = wrapped_q;
    pre_d     = pre_q;
    post_d    = post_q;
    mode_d    = mode_q;
    last_d    = last_q;
    trig      = 1'b0;
    autot     = 1'b0;
    stored    = 1'b0;
    rd_item   = 1'b0;
    unique case (item_i.cmd)
      CmdTick: begin
        if (fire) begin
          tick_d = '0;
          if (mode_q == ModeRun) begin
            stored = 1'b1;
            pre_d  = pre_inc;
            trig   = (pre_inc > PreW'(Half)) && crossed;
            autot  = !trig && (pre_inc >= PreW'(AutoMax));
            if (trig || autot) begin
              pre_d  = '0;
              post_d = '0;
              mode_d = ModeTrig;
            end
          end else if (mode_q == ModeTrig && post_q < PostW'(PostMax)) begin
            stored = 1'b1;
            post_d = post_q + PostW'(1);
          end else begin
            mode_d = ModeAvail;
          end
          if (stored) begin
            wi_d   = wi_next;
            last_d = item_i.sample;
            if (wi_q == IdxW'(DEPTH - 1)) begin
              wrapped_d = 1'b1;
            end
          end
        end else begin
          tick_d = tick_inc[PrescaleW-1:0];
        end
      end
      CmdRead: rd_item = 1'b1;
      CmdRearm: begin
        if (mode_q == ModeAvail) begin
          mode_d = ModeRun;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      wi_q      <= '0;
      wrapped_q <= 1'b0;
      pre_q     <= '0;
      post_q    <= '0;
      mode_q    <= ModeRun;
      last_q    <= '0;
    end else if (acc_i) begin
      tick_q    <= tick_d;
      wi_q      <= wi_d;
      wrapped_q <= wrapped_d;
      pre_q     <= pre_d;
      post_q    <= post_d;
      mode_q    <= mode_d;
      last_q    <= last_d;
    end
  end

  assign mem_we_o    = acc_i && stored;
  assign mem_waddr_o = wi_q;
  assign mem_wdata_o = item_i.sample;
  assign mem_re_o    = acc_i && rd_item;
  assign mem_raddr_o = rsum[IdxW-1:0];

  always_comb begin
    unique case (mode_d)
      ModeRun:   meta_o.capture_state = CapRunning;
      ModeTrig:  meta_o.capture_state = CapTriggered;
      ModeAvail: meta_o.capture_state = CapAvailable;
      default:   meta_o.capture_state = CapRunning;
    endcase
    meta_o.trigger_event = trig;
    meta_o.auto_event    = autot;
    meta_o.sample_stored = stored;
    // entries never written since reset read as zero
    meta_o.read_hit      = rd_item && (wrapped_q || (rsum[IdxW-1:0] < wi_q));
  end

endmodule

// ===== src/scope_edge_trigger_capture_core.sv =====
// A result is registered first in the stage-one register, beside the sample
// buffer RAM read data, and then in the output register. One item per cycle
// is taken while in_stall_o is low; the state update is combinational.
// Reset: asynchronous, clears control, config and pipeline valid state; the
// buffer has no clearing pass, entries not yet written read as zero.
// Top level: control, sample buffer RAM, result stage. Depends on setcap_pkg.
module scope_edge_trigger_capture_core #(
  parameter int unsigned DEPTH = setcap_pkg::DepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [setcap_pkg::CfgIdxW-1:0]      cfg_addr_i,
  input  logic [setcap_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  setcap_pkg::in_item_t                in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output setcap_pkg::out_item_t               out_data_o
);
  import setcap_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  cfg_wr_t              cfg;
  logic                 acc;
  logic                 mem_we, mem_re;
  logic [IdxW-1:0]      mem_waddr, mem_raddr;
  logic [SampleW-1:0]   mem_wdata, mem_rdata;
  res_meta_t            meta;
  res_meta_t            s1_meta_q;
  logic                 s1_valid_q;
  logic                 out_free, s1_move;
  logic                 out_valid_q;
  out_item_t            out_data_q;

  assign cfg_ready_o = 1'b1;
  assign cfg.en   = cfg_valid_i && cfg_ready_o;
  assign cfg.idx  = cfg_addr_i;
  assign cfg.data = cfg_wdata_i;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign acc        = in_valid_i && !in_stall_o;

  setcap_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .acc_i       (acc),
    .item_i      (in_data_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .meta_o      (meta)
  );

  setcap_ram #(.WIDTH(SampleW), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_meta_q <= meta;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q.capture_state <= s1_meta_q.capture_state;
      out_data_q.read_data     <= s1_meta_q.read_hit ? mem_rdata : '0;
      out_data_q.trigger_event <= s1_meta_q.trigger_event;
      out_data_q.auto_event    <= s1_meta_q.auto_event;
      out_data_q.sample_stored <= s1_meta_q.sample_stored;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/setcap_checker.sv =====
// Port-level checks on the capture block's result channel, with the bind
// that attaches them to the top level. Depends on setcap_pkg.
module setcap_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input setcap_pkg::out_item_t out_data_o
);
  import setcap_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a trigger always comes with a stored sample and the triggered state
  a_trig_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.trigger_event || out_data_o.auto_event) |->
      out_data_o.sample_stored &&
      (out_data_o.capture_state == CapTriggered) &&
      !(out_data_o.trigger_event && out_data_o.auto_event))
    else $error("trigger flags inconsistent");

  // read data only on read results, which carry no tick flags
  a_read_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.read_data != '0) |->
      !out_data_o.sample_stored && !out_data_o.trigger_event &&
      !out_data_o.auto_event)
    else $error("read data on a tick result");

  // nothing is stored once the waveform is available
  a_avail_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.capture_state == CapAvailable) |->
      !out_data_o.sample_stored)
    else $error("sample stored while available");

endmodule

bind scope_edge_trigger_capture_core setcap_checker u_setcap_checker (.*);
